@@ rtl/core/shift_jis_to_jis7_encoder_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Shift-JIS to JIS7 encoder
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SHIFT_JIS_TO_JIS7_ENCODER_MACROS_SVH
`define SHIFT_JIS_TO_JIS7_ENCODER_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold in the same cycle as its antecedent.
`define SJ2JIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Property whose consequence is checked in the cycle after the antecedent.
`define SJ2JIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SJ2JIS_ASSERT_NOW(lbl, ante, cons, msg)
`define SJ2JIS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/core/sj2jis_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shift-JIS to JIS7 encoder package
// Shared byte codes, burst type and encoder state type.
// ----------------------------------------------------------------------------
package sj2jis_pkg;

  // Escape sequence bytes.
  localparam logic [7:0] ESC_CODE  = 8'h1B;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_B      = 8'h42;

  // Longest output burst of one input beat and the width of its count.
  localparam int unsigned MAX_BURST = 8;
  localparam int unsigned BURST_CW  = $clog2(MAX_BURST + 1);

  typedef logic [7:0] byte_t;

  // Output bytes of one input beat, first byte in data[0].
  typedef struct packed {
    byte_t [MAX_BURST-1:0] data;
    logic  [BURST_CW-1:0]  count;
    logic                  eom;
  } burst_t;

  // Encoder state carried from one input beat to the next.
  typedef struct packed {
    logic  lead_held;
    byte_t lead_value;
    logic  kanji_mode;
  } enc_state_t;

endpackage

@@ rtl/core/shift_jis_to_jis7_encoder.sv @@
`timescale 1ns / 1ps
`include "shift_jis_to_jis7_encoder_macros.svh"
// ----------------------------------------------------------------------------
// Shift-JIS to JIS7 encoder
// Converts a Shift-JIS byte stream into 7-bit JIS with escape sequences.
// ----------------------------------------------------------------------------
// The encoder takes one Shift-JIS byte per input beat and turns it into a
// burst of zero to eight output beats in a single registered pass: the
// converter works from the input byte and the held encoder state, and the
// burst lands in the output burst register in the next cycle. A lead byte
// produces no output until its partner arrives; an ordinary byte produces one
// beat, or four when ESC ( B must leave kanji mode first; a kanji pair produces
// two or five, plus three more at message end. The output side sends one beat
// per cycle, so the input accepts a new byte every cycle as long as each burst
// is at most one byte long and the output does not stall, and otherwise stalls
// while the burst register drains. The next byte can enter in the same cycle
// as the last byte of the previous burst leaves. run_last_o marks the final
// beat caused by an input byte, and message_done_o marks the final beat of a
// message, which always has at least one output beat. After the message end
// the encoder is back in ASCII mode with no lead byte held.
// ----------------------------------------------------------------------------
module shift_jis_to_jis7_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       message_done_o
);
  import sj2jis_pkg::*;

  enc_state_t state_q, state_d;
  burst_t     burst;
  logic       can_load;
  logic       in_fire;

  // Input beats are taken whenever the burst register can be reloaded.
  assign in_stall_o = !can_load;
  assign in_fire    = in_valid_i && can_load;

  sj2jis_conv u_conv (
    .in_byte_i (in_byte_i),
    .eom_i     (end_of_message_i),
    .state_i   (state_q),
    .state_o   (state_d),
    .burst_o   (burst)
  );

  sj2jis_outq u_outq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (in_fire),
    .burst_i        (burst),
    .can_load_o     (can_load),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .run_last_o     (run_last_o),
    .message_done_o (message_done_o)
  );

  // Encoder state advances only on an accepted input beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  `SJ2JIS_ASSERT_NEXT(a_eom_clears, in_fire && end_of_message_i, !state_q.lead_held && !state_q.kanji_mode, "state not cleared at message end")
  `SJ2JIS_ASSERT_NEXT(a_lead_once, in_fire && state_q.lead_held, !state_q.lead_held, "lead byte held twice")
  `SJ2JIS_ASSERT_NEXT(a_eom_output, in_fire && end_of_message_i, out_valid_o, "message end without output")

endmodule

@@ rtl/core/sj2jis_conv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shift-JIS to JIS7 byte converter
// Forms the output burst and the next encoder state for one input byte.
// ----------------------------------------------------------------------------
module sj2jis_conv (
  input  logic [7:0]             in_byte_i,
  input  logic                   eom_i,
  input  sj2jis_pkg::enc_state_t state_i,
  output sj2jis_pkg::enc_state_t state_o,
  output sj2jis_pkg::burst_t     burst_o
);
  import sj2jis_pkg::*;

  logic  in_is_lead;
  logic  in_is_trail;
  byte_t hi_base;
  byte_t hi_byte;
  byte_t lo_dec;
  byte_t lo_byte;
  logic  lo_wrap;

  assign in_is_lead  = (in_byte_i >= 8'h81 && in_byte_i <= 8'h9F) ||
                       (in_byte_i >= 8'hE0 && in_byte_i <= 8'hFC);
  assign in_is_trail = (in_byte_i >= 8'h40 && in_byte_i <= 8'h7E) ||
                       (in_byte_i >= 8'h80 && in_byte_i <= 8'hFC);

  // JIS X 0208 row and cell from a Shift-JIS pair, kept to eight bits.
  assign hi_base = state_i.lead_value -
                   ((state_i.lead_value <= 8'h9F) ? 8'h71 : 8'hB1);
  assign lo_dec  = (in_byte_i > 8'h7F) ? (in_byte_i - 8'h01) : in_byte_i;
  assign lo_wrap = (lo_dec >= 8'h9E);
  assign lo_byte = lo_wrap ? (lo_dec - 8'h7D) : (lo_dec - 8'h1F);
  assign hi_byte = {hi_base[6:0], 1'b1} + {7'd0, lo_wrap};

  always_comb begin
    burst_t     b;
    enc_state_t s;
    b       = '0;
    s       = state_i;
    b.eom   = eom_i;
    if (state_i.lead_held) begin
      s.lead_held = 1'b0;
      if (in_is_trail) begin
        if (!state_i.kanji_mode) begin
          b.data[b.count[2:0]] = ESC_CODE;  b.count = b.count + 1'b1;
          b.data[b.count[2:0]] = CH_DOLLAR; b.count = b.count + 1'b1;
          b.data[b.count[2:0]] = CH_B;      b.count = b.count + 1'b1;
        end
        s.kanji_mode = 1'b1;
        b.data[b.count[2:0]] = hi_byte; b.count = b.count + 1'b1;
        b.data[b.count[2:0]] = lo_byte; b.count = b.count + 1'b1;
      end else begin
        if (state_i.kanji_mode) begin
          b.data[b.count[2:0]] = ESC_CODE;  b.count = b.count + 1'b1;
          b.data[b.count[2:0]] = CH_LPAREN; b.count = b.count + 1'b1;
          b.data[b.count[2:0]] = CH_B;      b.count = b.count + 1'b1;
        end
        s.kanji_mode = 1'b0;
        b.data[b.count[2:0]] = state_i.lead_value; b.count = b.count + 1'b1;
        b.data[b.count[2:0]] = in_byte_i;          b.count = b.count + 1'b1;
      end
      s.lead_value = '0;
    end else if (in_is_lead && !eom_i) begin
      s.lead_held  = 1'b1;
      s.lead_value = in_byte_i;
    end else begin
      if (state_i.kanji_mode) begin
        b.data[b.count[2:0]] = ESC_CODE;  b.count = b.count + 1'b1;
        b.data[b.count[2:0]] = CH_LPAREN; b.count = b.count + 1'b1;
        b.data[b.count[2:0]] = CH_B;      b.count = b.count + 1'b1;
      end
      s.kanji_mode = 1'b0;
      b.data[b.count[2:0]] = in_byte_i; b.count = b.count + 1'b1;
    end

    // Message end closes kanji mode and drops any held lead byte.
    if (eom_i) begin
      if (s.kanji_mode) begin
        b.data[b.count[2:0]] = ESC_CODE;  b.count = b.count + 1'b1;
        b.data[b.count[2:0]] = CH_LPAREN; b.count = b.count + 1'b1;
        b.data[b.count[2:0]] = CH_B;      b.count = b.count + 1'b1;
      end
      s.kanji_mode = 1'b0;
      s.lead_held  = 1'b0;
      s.lead_value = '0;
    end
    burst_o = b;
    state_o = s;
  end

endmodule

@@ rtl/core/sj2jis_outq.sv @@
`timescale 1ns / 1ps
`include "shift_jis_to_jis7_encoder_macros.svh"
// ----------------------------------------------------------------------------
// Shift-JIS to JIS7 output burst register
// Holds one burst and sends its bytes one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
module sj2jis_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  sj2jis_pkg::burst_t burst_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               run_last_o,
  output logic               message_done_o
);
  import sj2jis_pkg::*;

  byte_t [MAX_BURST-1:0] data_q, data_d;
  logic  [BURST_CW-1:0]  cnt_q, cnt_d;
  logic                  eom_q, eom_d;
  logic                  out_fire;

  assign out_valid_o    = (cnt_q != '0);
  assign out_fire       = out_valid_o && !out_stall_i;
  assign run_last_o     = (cnt_q == BURST_CW'(1));
  assign message_done_o = run_last_o && eom_q;
  assign out_byte_o     = data_q[0];
  // The burst register is free once its last byte leaves in this cycle.
  assign can_load_o     = !out_valid_o || (run_last_o && !out_stall_i);

  always_comb begin
    data_d = data_q;
    cnt_d  = cnt_q;
    eom_d  = eom_q;
    if (load_i) begin
      data_d = burst_i.data;
      cnt_d  = burst_i.count;
      eom_d  = burst_i.eom;
    end else if (out_fire) begin
      data_d = data_q >> 8;
      cnt_d  = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      eom_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      eom_q <= eom_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  `SJ2JIS_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= BURST_CW'(MAX_BURST), "burst count overflow")
  `SJ2JIS_ASSERT_NOW(a_load_free, load_i, can_load_o, "burst loaded while busy")
  `SJ2JIS_ASSERT_NEXT(a_burst_cont, out_fire && !run_last_o && !load_i, out_valid_o, "burst cut short")

endmodule

@@ tb/sv/shift_jis_to_jis7_encoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shift-JIS to JIS7 encoder testbench
// Drives Shift-JIS byte messages into the encoder and checks every JIS7 beat.
// ----------------------------------------------------------------------------
// The bench runs its own bit-accurate encoder model inside a small scoreboard.
// Each byte that the encoder accepts goes into the model. The model turns it
// into the burst of JIS7 beats that the byte must cause, and queues them in
// order. A monitor takes each beat that the encoder hands out and compares its
// byte, run_last and message_done against the oldest queued beat.
//
// Stimulus runs in phases:
//   - a short directed list that covers the byte extremes, both lead ranges,
//     both trail ranges, a lead followed by a non-trail byte in either mode,
//     a lead on the final byte, a kanji pair on the final byte, and byte zero;
//   - random messages built mostly from well-formed text (ASCII, kanji pairs,
//     half-width katakana), with some broken pairs and raw noise mixed in;
//   - a long receiver hold-off while the sender keeps offering kanji, so that
//     the encoder fills up and stalls its input, then a sender pause until
//     every queued beat has arrived;
//   - more random messages, then a last stretch where neither side idles.
// Both sides idle in random bursts, but the sender not in the hold-off and neither at the end.
// ----------------------------------------------------------------------------
module shift_jis_to_jis7_encoder_test;
  import sj2jis_pkg::*;

  // Shift-JIS byte classes and the conversion offsets of a kanji pair.
  localparam int unsigned SJ_LEAD1_LO  = 'h81;
  localparam int unsigned SJ_LEAD1_HI  = 'h9F;
  localparam int unsigned SJ_LEAD2_LO  = 'hE0;
  localparam int unsigned SJ_LEAD2_HI  = 'hFC;
  localparam int unsigned SJ_TRAIL1_LO = 'h40;
  localparam int unsigned SJ_TRAIL1_HI = 'h7E;
  localparam int unsigned SJ_TRAIL2_LO = 'h80;
  localparam int unsigned SJ_TRAIL2_HI = 'hFC;
  localparam int unsigned SJ_DEL       = 'h7F;
  localparam int unsigned ROW_OFS_LOW  = 'h71;
  localparam int unsigned ROW_OFS_HIGH = 'hB1;
  localparam int unsigned COL_SPLIT    = 'h9E;
  localparam int unsigned COL_OFS_HIGH = 'h7D;
  localparam int unsigned COL_OFS_LOW  = 'h1F;

  // Run shape.
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned DRAIN_LIMIT  = 20000;

  // Directed list: bit 8 is the end-of-message flag, bits 7:0 the byte.
  localparam logic [8:0] DIRECTED_SEQ [22] = '{
    9'h000, 9'h0FF, 9'h07F,          // zero, all ones, DEL as plain data
    9'h081, 9'h040,                  // lowest lead with lowest trail
    9'h09F, 9'h0FC,                  // top of the first lead range, top trail
    9'h0E0, 9'h07E,                  // bottom of the second lead range
    9'h0FC, 9'h080,                  // top lead, first trail above DEL
    9'h041,                          // plain byte leaves kanji mode
    9'h081, 9'h07F,                  // lead then non-trail in ASCII mode
    9'h088, 9'h0A0,                  // back into kanji mode
    9'h09F, 9'h0FD,                  // lead then non-trail in kanji mode
    9'h1E5,                          // lead on the final byte
    9'h093, 9'h1FA,                  // kanji pair that closes the message
    9'h130                           // one plain byte as a whole message
  };

  typedef struct packed {
    byte_t data;
    logic  run_last;
    logic  message_done;
  } jis_beat_t;

  // Encoder model and the queue of JIS7 beats still owed by the block.
  class jis7_scoreboard;
    logic      lead_held;
    byte_t     lead_value;
    logic      kanji_mode;
    byte_t     burst[$];
    jis_beat_t jis_beats_due[$];
    int        errors;

    function new();
      lead_held  = 1'b0;
      lead_value = '0;
      kanji_mode = 1'b0;
      errors     = 0;
    endfunction

    function bit is_lead(byte_t b);
      return (b >= SJ_LEAD1_LO && b <= SJ_LEAD1_HI) ||
             (b >= SJ_LEAD2_LO && b <= SJ_LEAD2_HI);
    endfunction

    function bit is_trail(byte_t b);
      return (b >= SJ_TRAIL1_LO && b <= SJ_TRAIL1_HI) ||
             (b >= SJ_TRAIL2_LO && b <= SJ_TRAIL2_HI);
    endfunction

    function void leave_kanji();
      if (kanji_mode) begin
        burst.push_back(ESC_CODE);
        burst.push_back(CH_LPAREN);
        burst.push_back(CH_B);
        kanji_mode = 1'b0;
      end
    endfunction

    function void put_plain(byte_t b);
      leave_kanji();
      burst.push_back(b);
    endfunction

    function void put_kanji(byte_t lead, byte_t trail);
      int unsigned row;
      int unsigned col;
      if (!kanji_mode) begin
        burst.push_back(ESC_CODE);
        burst.push_back(CH_DOLLAR);
        burst.push_back(CH_B);
        kanji_mode = 1'b1;
      end
      row = lead;
      row = (row - ((row <= SJ_LEAD1_HI) ? ROW_OFS_LOW : ROW_OFS_HIGH)) * 2 + 1;
      col = trail;
      if (col > SJ_DEL) col = col - 1;
      if (col >= COL_SPLIT) begin
        col = col - COL_OFS_HIGH;
        row = row + 1;
      end else begin
        col = col - COL_OFS_LOW;
      end
      burst.push_back(row[7:0]);
      burst.push_back(col[7:0]);
    endfunction

    // Runs one accepted Shift-JIS byte through the model and queues the
    // JIS7 beats it causes.
    function void note_sjis_byte(byte_t b, logic eom);
      jis_beat_t beat;
      burst = {};
      if (lead_held) begin
        lead_held = 1'b0;
        if (is_trail(b)) begin
          put_kanji(lead_value, b);
        end else begin
          put_plain(lead_value);
          put_plain(b);
        end
        lead_value = '0;
      end else if (is_lead(b) && !eom) begin
        lead_held  = 1'b1;
        lead_value = b;
      end else begin
        put_plain(b);
      end
      if (eom) begin
        leave_kanji();
        lead_held  = 1'b0;
        lead_value = '0;
      end
      foreach (burst[k]) begin
        beat.data         = burst[k];
        beat.run_last     = (k == burst.size() - 1);
        beat.message_done = (k == burst.size() - 1) && eom;
        jis_beats_due.push_back(beat);
      end
    endfunction

    function void check_jis_beat(byte_t data, logic run_last, logic message_done);
      jis_beat_t want;
      if (jis_beats_due.size() == 0) begin
        $display("%0t ns: output beat with none due: expected nothing, actual byte %h",
                 $time, data);
        errors++;
        return;
      end
      want = jis_beats_due.pop_front();
      if (data !== want.data) begin
        $display("%0t ns: out_byte mismatch: expected %h, actual %h",
                 $time, want.data, data);
        errors++;
      end
      if (run_last !== want.run_last) begin
        $display("%0t ns: run_last mismatch: expected %b, actual %b",
                 $time, want.run_last, run_last);
        errors++;
      end
      if (message_done !== want.message_done) begin
        $display("%0t ns: message_done mismatch: expected %b, actual %b",
                 $time, want.message_done, message_done);
        errors++;
      end
    endfunction

    function int beats_due();
      return jis_beats_due.size();
    endfunction

    function void close_out();
      if (jis_beats_due.size() != 0) begin
        $display("%0t ns: beats never delivered: expected %0d more, actual 0",
                 $time, jis_beats_due.size());
        errors++;
      end
    endfunction
  endclass

  logic  clk_i;
  logic  rst_ni           = 1'b0;
  logic  in_valid_i       = 1'b0;
  logic  in_stall_o;
  byte_t in_byte_i        = '0;
  logic  end_of_message_i = 1'b0;
  logic  out_valid_o;
  logic  out_stall_i      = 1'b0;
  byte_t out_byte_o;
  logic  run_last_o;
  logic  message_done_o;

  jis7_scoreboard sb = new();

  // Phase controls shared by the sender, the receiver and the main sequence.
  bit sender_idle_on   = 1'b1;
  bit receiver_idle_on = 1'b1;
  bit hold_request     = 1'b0;
  int bytes_sent       = 0;

  shift_jis_to_jis7_encoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .end_of_message_i(end_of_message_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .run_last_o      (run_last_o),
    .message_done_o  (message_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the encoder hangs; far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("** shift_jis_to_jis7_encoder: FAILED **");
    $finish;
  end

  // All inputs and outputs are read right at the rising edge, before any
  // nonblocking update of that edge lands, so every read sees the values
  // that the edge itself samples.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_jis_beat(out_byte_o, run_last_o, message_done_o);
    end
  end

  // Receiver: random stall bursts, or one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i  <= 1'b0;
        hold_request = 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offers one byte and returns in the time step of the edge that takes it.
  // The payload holds steady for as long as the encoder stalls.
  task automatic send_beat(byte_t b, logic eom);
    in_valid_i       <= 1'b1;
    in_byte_i        <= b;
    end_of_message_i <= eom;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_sjis_byte(b, eom);
    bytes_sent++;
  endtask

  // One byte followed, now and then, by an idle burst on the input side.
  task automatic send_byte(byte_t b, logic eom);
    send_beat(b, eom);
    if (sender_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  function automatic byte_t random_lead();
    return $urandom_range(0, 1) ? byte_t'($urandom_range(SJ_LEAD1_LO, SJ_LEAD1_HI))
                                : byte_t'($urandom_range(SJ_LEAD2_LO, SJ_LEAD2_HI));
  endfunction

  function automatic byte_t random_trail();
    return $urandom_range(0, 1) ? byte_t'($urandom_range(SJ_TRAIL1_LO, SJ_TRAIL1_HI))
                                : byte_t'($urandom_range(SJ_TRAIL2_LO, SJ_TRAIL2_HI));
  endfunction

  // A byte that can neither start nor finish a kanji pair.
  function automatic byte_t random_non_trail();
    case ($urandom_range(0, 2))
      0:       return byte_t'($urandom_range(0, SJ_TRAIL1_LO - 1));
      1:       return byte_t'(SJ_DEL);
      default: return byte_t'($urandom_range(SJ_LEAD2_HI + 1, 'hFF));
    endcase
  endfunction

  // One message of 1 to 10 characters. Most characters are well-formed text,
  // so kanji mode is entered and left often; the rest break pairs or are
  // arbitrary bytes. The end flag sits on the last byte of the last character.
  task automatic send_random_message();
    int chars;
    int pick;
    bit eom;
    chars = $urandom_range(1, 10);
    for (int i = 0; i < chars; i++) begin
      eom  = (i == chars - 1);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_byte(byte_t'($urandom_range('h20, 'h7E)), eom);
      end else if (pick < 70) begin
        send_byte(random_lead(), 1'b0);
        send_byte(random_trail(), eom);
      end else if (pick < 78) begin
        // Half-width katakana sits between the two lead ranges.
        send_byte(byte_t'($urandom_range('hA1, 'hDF)), eom);
      end else if (pick < 86) begin
        send_byte(random_lead(), 1'b0);
        send_byte(random_non_trail(), eom);
      end else if (pick < 92) begin
        // A lone lead; mid-message the next character becomes its partner.
        send_byte(random_lead(), eom);
      end else begin
        send_byte(byte_t'($urandom_range(0, 'hFF)), eom);
      end
    end
  endtask

  task automatic send_random_until(int target);
    while (bytes_sent < target) send_random_message();
  endtask

  // Drops valid and waits until the encoder has handed out every beat due.
  task automatic wait_all_delivered();
    in_valid_i <= 1'b0;
    for (int i = 0; sb.beats_due() != 0 && i < DRAIN_LIMIT; i++) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_SEQ[i]) begin
      send_byte(DIRECTED_SEQ[i][7:0], DIRECTED_SEQ[i][8]);
    end

    send_random_until(200);

    // The receiver holds off for a long stretch while twelve kanji pairs
    // keep coming, so the burst register fills and the input stalls.
    sender_idle_on = 1'b0;
    hold_request   = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_beat(random_lead(), 1'b0);
      send_beat(random_trail(), i == 11);
    end
    wait (!hold_request);
    wait_all_delivered();
    sender_idle_on = 1'b1;

    send_random_until(310);

    // Last stretch at full rate on both sides.
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    send_random_until(355);

    wait_all_delivered();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("** shift_jis_to_jis7_encoder: PASSED **");
    end else begin
      $display("** shift_jis_to_jis7_encoder: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/sj2jis_pkg.sv
rtl/core/sj2jis_conv.sv
rtl/core/sj2jis_outq.sv
rtl/core/shift_jis_to_jis7_encoder.sv
tb/sv/shift_jis_to_jis7_encoder_test.sv
